// ----- hdl/tvp_pkg.sv -----
`timescale 1ns / 1ps

package tvp_pkg;

   localparam int RATE_BITS_DEFAULT  = 18;
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int FACTOR_BITS        = 17;
   localparam int ACCEL_BITS         = 24;
   localparam int MIN_RATE_BITS      = 16;
   localparam logic [MIN_RATE_BITS-1:0] MIN_RATE_RESET = 16'd120;
   localparam int Q16_SHIFT          = 16;

   // per-item flags carried alongside the divider pipeline
   typedef struct packed {
      logic busy;
      logic a_zero;
      logic num_neg;
   } tvp_flags_type;

endpackage

// ----- hdl/tvp_div.sv -----
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module tvp_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 26,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic             out_rem_nz,
   output logic [PAY_W-1:0] out_pay
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [PAY_W-1:0] pay_ff [NUM_W];
   logic             vld_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] src_rem;
      logic [NUM_W-1:0] src_nq;
      logic [DEN_W-1:0] src_den;
      logic [PAY_W-1:0] src_pay;
      logic             src_vld;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign src_rem = '0;
         assign src_nq  = in_num;
         assign src_den = in_den;
         assign src_pay = in_pay;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_nq  = nq_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_pay = pay_ff[k-1];
         assign src_vld = vld_ff[k-1];
      end

      assign trial  = {src_rem, src_nq[NUM_W-1]};
      assign diff   = trial - {1'b0, src_den};
      assign ge     = (trial >= {1'b0, src_den});
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= {src_nq[NUM_W-2:0], ge};
            den_ff[k] <= src_den;
            pay_ff[k] <= src_pay;
         end
      end
   end

   assign out_valid  = vld_ff[NUM_W-1];
   assign out_quot   = nq_ff[NUM_W-1];
   assign out_rem_nz = |rem_ff[NUM_W-1];
   assign out_pay    = pay_ff[NUM_W-1];

endmodule

// ----- hdl/trapezoid_velocity_profile_top.sv -----
`timescale 1ns / 1ps
// each req beat passes stages 1-4, the NW-bit dividers, stages e, f and the output register,
//   where NW = max(ACCEL_BITS + 1 + COUNT_BITS, 2 * RATE_BITS) + 1 (50 at the defaults)
// throughput: one beat per cycle when not stalled; bit-per-stage dividers set the depth
// the whole pipeline holds while a result waits on rsp_tready
// reset: synchronous, clears all valid bits and sets the minimum rate to 120
module trapezoid_velocity_profile_top #(
   parameter int RATE_BITS  = tvp_pkg::RATE_BITS_DEFAULT,
   parameter int COUNT_BITS = tvp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // lowest bit up: cruise rate, entry ratio, exit ratio, accel_rate, step_count
   input  logic [((RATE_BITS + 2*tvp_pkg::FACTOR_BITS + tvp_pkg::ACCEL_BITS
                   + COUNT_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // segment_busy
   input  logic req_tuser,
   input  logic req_tvalid,
   output logic req_tready,
   // lowest bit up: accel end step, decel start step, start_rate, end_rate
   output logic [((2*COUNT_BITS + 3 + 2*RATE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // profile_written
   output logic rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  logic [tvp_pkg::MIN_RATE_BITS-1:0] csr_wr_data
);

   localparam int R   = RATE_BITS;
   localparam int C   = COUNT_BITS;
   localparam int F   = tvp_pkg::FACTOR_BITS;
   localparam int A   = tvp_pkg::ACCEL_BITS;
   localparam int M   = tvp_pkg::MIN_RATE_BITS;
   localparam int NW  = (((A + 1 + C) > 2*R) ? (A + 1 + C) : 2*R) + 1;
   localparam int DW  = A + 2;
   localparam int SW  = NW + 2;
   localparam int PW  = SW + 2;
   localparam int CW  = ((R + 2) > M) ? (R + 2) : M;
   localparam int SIDE_W = 3 + C + 2*R;
   localparam int OUT_W  = 2*C + 3 + 2*R;
   localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

   logic en;
   logic [M-1:0] min_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rate_ff <= tvp_pkg::MIN_RATE_RESET;
      end else if (csr_wr_en) begin
         min_rate_ff <= csr_wr_data;
      end
   end

   function automatic logic [R-1:0] clamp_rate(input logic [R+1:0] r, input logic [M-1:0] mn);
      logic [CW-1:0] v;
      logic [CW-1:0] mnw;
      logic [CW-1:0] top;
      v   = CW'(r);
      mnw = CW'(mn);
      top = CW'({R{1'b1}});
      if (v < mnw) v = mnw;
      if (v > top) v = top;
      return v[R-1:0];
   endfunction

   function automatic logic [C:0] sat_acc(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      logic signed [PW-1:0] r;
      hi = PW'({1'b0, {C{1'b1}}});
      lo = -hi - PW'(1);
      r  = v;
      if (v > hi) r = hi;
      if (v < lo) r = lo;
      return r[C:0];
   endfunction

   function automatic logic [C+1:0] sat_da(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      logic signed [PW-1:0] r;
      hi = PW'({1'b0, {(C+1){1'b1}}});
      lo = -hi - PW'(1);
      r  = v;
      if (v > hi) r = hi;
      if (v < lo) r = lo;
      return r[C+1:0];
   endfunction

   // input field split
   logic [R-1:0] in_n;
   logic [F-1:0] in_ef;
   logic [F-1:0] in_xf;
   logic [A-1:0] in_a;
   logic [C-1:0] in_d;

   assign in_n  = req_tdata[R-1:0];
   assign in_ef = req_tdata[R+F-1:R];
   assign in_xf = req_tdata[R+2*F-1:R+F];
   assign in_a  = req_tdata[R+2*F+A-1:R+2*F];
   assign in_d  = req_tdata[R+2*F+A+C-1:R+2*F+A];

   // stage 1: rate products and a*d
   logic           s1_vld_ff;
   logic [R+F-1:0] s1_pe_ff, s1_px_ff;
   logic [A+C-1:0] s1_ad_ff;
   logic [R-1:0]   s1_n_ff;
   logic [A-1:0]   s1_a_ff;
   logic [C-1:0]   s1_d_ff;
   logic           s1_busy_ff;

   // stage 2: start and end rates, rounded up and clamped to [min rate, max rate]
   logic           s2_vld_ff;
   logic [R-1:0]   s2_ri_ff, s2_rf_ff, s2_n_ff;
   logic [A+C-1:0] s2_ad_ff;
   logic [A-1:0]   s2_a_ff;
   logic [C-1:0]   s2_d_ff;
   logic           s2_busy_ff;
   logic [R+F:0]   s2_se, s2_sx;

   // stage 3: squares
   logic           s3_vld_ff;
   logic [2*R-1:0] s3_nn_ff, s3_ii_ff, s3_ff_ff;
   logic [R-1:0]   s3_ri_ff, s3_rf_ff;
   logic [A+C-1:0] s3_ad_ff;
   logic [A-1:0]   s3_a_ff;
   logic [C-1:0]   s3_d_ff;
   logic           s3_busy_ff;

   // stage 4: numerators as sign and magnitude
   logic           s4_vld_ff;
   logic [NW-1:0]  s4_m1_ff, s4_m2_ff, s4_m3_ff;
   logic           s4_g1_ff, s4_g2_ff, s4_g3_ff;
   logic [DW-1:0]  s4_den2_ff, s4_den4_ff;
   logic           s4_az_ff;
   logic [R-1:0]   s4_ri_ff, s4_rf_ff;
   logic [C-1:0]   s4_d_ff;
   logic           s4_busy_ff;
   logic [2*R:0]   n1, n2, n1m, n2m;
   logic [NW:0]    n3, n3m;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   assign s2_se = {1'b0, s1_pe_ff} + (R+F+1)'(65535);
   assign s2_sx = {1'b0, s1_px_ff} + (R+F+1)'(65535);

   assign n1  = {1'b0, s3_nn_ff} - {1'b0, s3_ii_ff};
   assign n2  = {1'b0, s3_nn_ff} - {1'b0, s3_ff_ff};
   assign n1m = n1[2*R] ? -n1 : n1;
   assign n2m = n2[2*R] ? -n2 : n2;
   assign n3  = (NW+1)'({s3_ad_ff, 1'b0}) - (NW+1)'(s3_ii_ff) + (NW+1)'(s3_ff_ff);
   assign n3m = n3[NW] ? -n3 : n3;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pe_ff   <= in_n * in_ef;
         s1_px_ff   <= in_n * in_xf;
         s1_ad_ff   <= in_a * in_d;
         s1_n_ff    <= in_n;
         s1_a_ff    <= in_a;
         s1_d_ff    <= in_d;
         s1_busy_ff <= req_tuser;

         s2_ri_ff   <= clamp_rate(s2_se[R+F:tvp_pkg::Q16_SHIFT], min_rate_ff);
         s2_rf_ff   <= clamp_rate(s2_sx[R+F:tvp_pkg::Q16_SHIFT], min_rate_ff);
         s2_n_ff    <= s1_n_ff;
         s2_ad_ff   <= s1_ad_ff;
         s2_a_ff    <= s1_a_ff;
         s2_d_ff    <= s1_d_ff;
         s2_busy_ff <= s1_busy_ff;

         s3_nn_ff   <= s2_n_ff * s2_n_ff;
         s3_ii_ff   <= s2_ri_ff * s2_ri_ff;
         s3_ff_ff   <= s2_rf_ff * s2_rf_ff;
         s3_ri_ff   <= s2_ri_ff;
         s3_rf_ff   <= s2_rf_ff;
         s3_ad_ff   <= s2_ad_ff;
         s3_a_ff    <= s2_a_ff;
         s3_d_ff    <= s2_d_ff;
         s3_busy_ff <= s2_busy_ff;

         s4_m1_ff   <= NW'(n1m[2*R-1:0]);
         s4_m2_ff   <= NW'(n2m[2*R-1:0]);
         s4_m3_ff   <= n3m[NW-1:0];
         s4_g1_ff   <= n1[2*R];
         s4_g2_ff   <= n2[2*R];
         s4_g3_ff   <= n3[NW];
         s4_den2_ff <= DW'({s3_a_ff, 1'b0});
         s4_den4_ff <= {s3_a_ff, 2'b00};
         s4_az_ff   <= (s3_a_ff == '0);
         s4_ri_ff   <= s3_ri_ff;
         s4_rf_ff   <= s3_rf_ff;
         s4_d_ff    <= s3_d_ff;
         s4_busy_ff <= s3_busy_ff;
      end
   end

   // dividers
   tvp_pkg::tvp_flags_type s4_flags, q_flags;
   logic [SIDE_W-1:0] side_in, side_out;
   logic              q_vld, q2_vld, q3_vld;
   logic [NW-1:0]     q1, q2, q3;
   logic              q1_nz, q2_nz, q3_nz;
   logic              q2_neg, q3_neg;
   logic [C-1:0]      q_d;
   logic [R-1:0]      q_ri, q_rf;

   assign s4_flags.busy    = s4_busy_ff;
   assign s4_flags.a_zero  = s4_az_ff;
   assign s4_flags.num_neg = s4_g1_ff;
   assign side_in = {s4_flags, s4_d_ff, s4_ri_ff, s4_rf_ff};
   assign {q_flags, q_d, q_ri, q_rf} = side_out;

   tvp_div #(.NUM_W(NW), .DEN_W(DW), .PAY_W(SIDE_W)) u_div_acc (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s4_vld_ff), .in_num(s4_m1_ff), .in_den(s4_den2_ff), .in_pay(side_in),
      .out_valid(q_vld), .out_quot(q1), .out_rem_nz(q1_nz), .out_pay(side_out)
   );

   tvp_div #(.NUM_W(NW), .DEN_W(DW), .PAY_W(1)) u_div_dec (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s4_vld_ff), .in_num(s4_m2_ff), .in_den(s4_den2_ff), .in_pay(s4_g2_ff),
      .out_valid(q2_vld), .out_quot(q2), .out_rem_nz(q2_nz), .out_pay(q2_neg)
   );

   tvp_div #(.NUM_W(NW), .DEN_W(DW), .PAY_W(1)) u_div_meet (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s4_vld_ff), .in_num(s4_m3_ff), .in_den(s4_den4_ff), .in_pay(s4_g3_ff),
      .out_valid(q3_vld), .out_quot(q3), .out_rem_nz(q3_nz), .out_pay(q3_neg)
   );

   // stage e: signed ceil and floor
   logic                 e_vld_ff;
   logic signed [SW-1:0] e_acc_ff, e_dec_ff, e_meet_ff;
   logic [C-1:0]         e_d_ff;
   logic [R-1:0]         e_ri_ff, e_rf_ff;
   logic                 e_busy_ff;
   logic signed [SW-1:0] qs1, qs2, qs3, acc_c, dec_c, meet_c;

   assign qs1 = SW'(q1);
   assign qs2 = SW'(q2);
   assign qs3 = SW'(q3);
   assign acc_c  = q_flags.num_neg ? -qs1 : qs1 + SW'(q1_nz);
   assign dec_c  = q2_neg ? -(qs2 + SW'(q2_nz)) : qs2;
   assign meet_c = q3_neg ? -qs3 : qs3 + SW'(q3_nz);

   // stage f: plateau test and braking point
   logic                 f_vld_ff;
   logic signed [PW-1:0] f_acc_ff, f_da_ff;
   logic [R-1:0]         f_ri_ff, f_rf_ff;
   logic                 f_busy_ff;
   logic signed [PW-1:0] d_p, plat, da_c;
   logic signed [SW-1:0] d_s, meet_cl;

   assign d_s  = SW'({1'b0, e_d_ff});
   assign d_p  = PW'({1'b0, e_d_ff});
   assign plat = d_p - PW'(e_acc_ff) - PW'(e_dec_ff);
   assign da_c = d_p - PW'(e_dec_ff);

   always_comb begin
      meet_cl = e_meet_ff;
      if (e_meet_ff < 0) meet_cl = '0;
      else if (e_meet_ff > d_s) meet_cl = d_s;
   end

   // output register
   logic           out_vld_ff;
   logic [OUT_W-1:0] out_data_ff;
   logic           out_wr_ff;

   assign en = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff   <= 1'b0;
         f_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff   <= q_vld;
         f_vld_ff   <= e_vld_ff;
         out_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_acc_ff  <= q_flags.a_zero ? '0 : acc_c;
         e_dec_ff  <= q_flags.a_zero ? '0 : dec_c;
         e_meet_ff <= q_flags.a_zero ? '0 : meet_c;
         e_d_ff    <= q_d;
         e_ri_ff   <= q_ri;
         e_rf_ff   <= q_rf;
         e_busy_ff <= q_flags.busy;

         f_acc_ff  <= (plat < 0) ? PW'(meet_cl) : PW'(e_acc_ff);
         f_da_ff   <= (plat < 0) ? PW'(meet_cl) : da_c;
         f_ri_ff   <= e_ri_ff;
         f_rf_ff   <= e_rf_ff;
         f_busy_ff <= e_busy_ff;

         // busy segment gives an all-zero beat
         out_data_ff <= f_busy_ff ? '0 :
                        {f_rf_ff, f_ri_ff, sat_da(f_da_ff), sat_acc(f_acc_ff)};
         out_wr_ff   <= !f_busy_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_wr_ff;
   assign rsp_tdata  = OUT_PW'(out_data_ff);

   logic [R-1:0]        chk_ri;

   assign chk_ri  = out_data_ff[2*C+2+R:2*C+3];

   a_busy_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (out_data_ff == '0))
      else $error("busy beat carries nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result beat changed while stalled");

   a_div_sync: assert property (@(posedge clock) disable iff (reset)
      (q2_vld == q_vld) && (q3_vld == q_vld))
      else $error("divider pipelines out of step");

   a_min_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && (CW'(min_rate_ff) <= CW'({R{1'b1}})))
         |-> (CW'(chk_ri) >= CW'(min_rate_ff)))
      else $error("start rate below minimum");

endmodule
